/* rtl/core/jads_pkg.sv */
package jads_pkg;

  // Sample and axis geometry
  localparam int ADC_BITS = 10;
  localparam int NUM_AXES = 2;
  localparam int AXIS_W   = 1;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 8;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [ADC_BITS-1:0] ADC_MAX      = {ADC_BITS{1'b1}};
  localparam logic [ADC_BITS-1:0] ADC_HALF     = ADC_MAX >> 1;
  localparam logic [ADC_BITS-1:0] CENTRE_RESET = ADC_BITS'(511);
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = {COUNT_W{1'b1}};

  // Divider geometry: quotient bits rounded to whole radix-4 digits
  localparam int Q_W         = (ADC_BITS / 2) * 2;
  localparam int NUM_W       = ADC_BITS + Q_W;
  localparam int X_W         = ADC_BITS + BYTE_W;
  localparam int DIG_W       = $clog2(Q_W / 2 + 1);
  localparam logic [DIG_W-1:0] POS_DIGITS  = DIG_W'(Q_W / 2);
  localparam logic [DIG_W-1:0] BYTE_DIGITS = DIG_W'(BYTE_W / 2);

  // Register map
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_X    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_Y    = 2'd3;

  localparam logic [CFG_W-1:0] DEADZONE_RESET = 8'd3;
  localparam logic [CFG_W-1:0] STABLE_RESET   = 8'd10;

  // Item opcodes
  localparam logic OP_POSITION  = 1'b0;
  localparam logic OP_CALIBRATE = 1'b1;

  typedef struct packed {
    logic                start;
    logic [DIG_W-1:0]    ndig;
    logic [ADC_BITS-1:0] rem_init;
    logic [Q_W-1:0]      bits;
    logic [ADC_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quo;
  } div_rsp_t;

endpackage

/* rtl/core/jads_in_if.sv */
interface jads_in_if;
  import jads_pkg::*;

  logic                valid;
  logic                ready;
  logic                opcode;
  logic [AXIS_W-1:0]   axis;
  logic [ADC_BITS-1:0] sample;
  logic [ADC_BITS-1:0] second_sample;

  modport source (output valid, output opcode, output axis, output sample,
                  output second_sample, input ready);
  modport sink   (input valid, input opcode, input axis, input sample,
                  input second_sample, output ready);
endinterface

/* rtl/core/jads_out_if.sv */
interface jads_out_if;
  import jads_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] position;
  logic [AXIS_W-1:0] axis_out;
  logic              axis_calibrated;
  logic              centre_latched;

  modport source (output valid, output position, output axis_out,
                  output axis_calibrated, output centre_latched, input ready);
  modport sink   (input valid, input position, input axis_out,
                  input axis_calibrated, input centre_latched, output ready);
endinterface

/* rtl/core/jads_div.sv */
// Radix-4 restoring divider, two quotient bits per cycle.
// rem_init must be below den; bits are shifted in MSB first.
module jads_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jads_pkg::div_req_t req_i,
  output jads_pkg::div_rsp_t rsp_o
);
  import jads_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DIG_W-1:0]    cnt_q, cnt_d;
  logic [ADC_BITS-1:0] rem_q, rem_d;
  logic [ADC_BITS-1:0] den_q, den_d;
  logic [Q_W-1:0]      sh_q, sh_d;
  logic [Q_W-1:0]      quo_q, quo_d;

  logic [ADC_BITS+1:0] trial, d1, d2, d3, sub;
  logic [1:0]          digit;

  always_comb begin
    trial = {rem_q, sh_q[Q_W-1 -: 2]};
    d1    = (ADC_BITS+2)'(den_q);
    d2    = d1 << 1;
    d3    = d1 + d2;
    priority if (trial >= d3) begin
      digit = 2'd3;
      sub   = d3;
    end else if (trial >= d2) begin
      digit = 2'd2;
      sub   = d2;
    end else if (trial >= d1) begin
      digit = 2'd1;
      sub   = d1;
    end else begin
      digit = 2'd0;
      sub   = '0;
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    sh_d   = sh_q;
    quo_d  = quo_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = req_i.ndig;
      rem_d  = req_i.rem_init;
      den_d  = req_i.den;
      sh_d   = req_i.bits;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ADC_BITS'(trial - sub);
      sh_d  = sh_q << 2;
      quo_d = {quo_q[Q_W-3:0], digit};
      cnt_d = cnt_q - DIG_W'(1);
      if (cnt_q == DIG_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    sh_q  <= sh_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

/* rtl/core/joystick_axis_deadzone_scaler.sv */
// Channel  | Dir | Handshake    | Payload
// ---------+-----+--------------+---------------------------------------------
// in_i     | in  | valid/ready  | opcode, axis, sample, second_sample
// out_o    | out | valid/ready  | position, axis_out, axis_calibrated,
//          |     |              | centre_latched
// cfg      | in  | cfg_we_i     | cfg_idx_i, cfg_data_i (write only)
//
// One item at a time. A calibration item or an item for an absent axis
// skips the divider and goes to the output register; a position item in the
// neutral band runs only the byte reduction (4 digit steps), one outside
// it first the band projection (5 digit steps). The input is ready again
// in the cycle after the result is loaded.
// Reset is asynchronous, active low, and restores register and axis defaults.
// A stalled output holds its result; the block finishes the next item up to
// the output register and waits there.
module joystick_axis_deadzone_scaler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [jads_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [jads_pkg::CFG_W-1:0]     cfg_data_i,
  jads_in_if.sink                        in_i,
  jads_out_if.source                     out_o
);
  import jads_pkg::*;

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;  // band compare, launch divider
  localparam logic [2:0] ST_PASS1 = 3'd2;  // band projection division
  localparam logic [2:0] ST_PASS2 = 3'd3;  // byte reduction division
  localparam logic [2:0] ST_DONE  = 3'd4;  // wait for output register

  logic [2:0] state_q, state_d;

  // Configuration
  logic [CFG_W-1:0] radius_q, stable_q;
  logic             rev_x_q, rev_y_q;

  // Per-axis calibration state
  logic [ADC_BITS-1:0] centre_q [NUM_AXES];
  logic [COUNT_W-1:0]  count_q  [NUM_AXES];
  logic [NUM_AXES-1:0] cal_q;

  // Item in flight
  logic [ADC_BITS-1:0] s_q, lower_q, upper_q;
  logic [AXIS_W-1:0]   axis_q;
  logic                rev_q, above_q;
  logic [BYTE_W-1:0]   res_pos_q;
  logic                res_cal_q, res_lat_q;

  // Output register
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_pos_q;
  logic [AXIS_W-1:0] out_axis_q;
  logic              out_cal_q, out_lat_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic accept, out_load;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  // ---------------------------------------------------------------------------
  // Axis lookup and calibration decision at input transfer
  // ---------------------------------------------------------------------------
  logic                axis_ok, cal_sel, pair_eq, latch_now, is_cal;
  logic [ADC_BITS-1:0] centre_sel, lower_d, upper_d;
  logic [ADC_BITS:0]   upper_sum;
  logic [COUNT_W-1:0]  cnt_sel, cnt_inc, need;

  always_comb begin
    axis_ok    = 1'b0;
    centre_sel = CENTRE_RESET;
    cal_sel    = 1'b0;
    cnt_sel    = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (int'(in_i.axis) == i) begin
        axis_ok    = 1'b1;
        centre_sel = centre_q[i];
        cal_sel    = cal_q[i];
        cnt_sel    = count_q[i];
      end
    end
  end

  always_comb begin
    is_cal    = (in_i.opcode == OP_CALIBRATE);
    pair_eq   = (in_i.sample == in_i.second_sample);
    cnt_inc   = (cnt_sel == COUNT_MAX) ? cnt_sel : cnt_sel + COUNT_W'(1);
    // zero stable_pairs acts as one
    need      = (stable_q == '0) ? COUNT_W'(1) : stable_q;
    latch_now = is_cal && axis_ok && pair_eq && (cnt_inc >= need);

    // neutral band, clamped to the ADC range
    lower_d   = (centre_sel > ADC_BITS'(radius_q)) ?
                centre_sel - ADC_BITS'(radius_q) : '0;
    upper_sum = (ADC_BITS+1)'(centre_sel) + (ADC_BITS+1)'(radius_q);
    upper_d   = (upper_sum > (ADC_BITS+1)'(ADC_MAX)) ?
                ADC_MAX : upper_sum[ADC_BITS-1:0];
  end

  // ---------------------------------------------------------------------------
  // Divider operands
  // ---------------------------------------------------------------------------
  logic                below, above, pass1;
  logic [ADC_BITS-1:0] diff, den1, v_sel;
  logic [NUM_W-1:0]    num1;
  logic [X_W-1:0]      x;

  always_comb begin
    below = (s_q < lower_q);
    above = (s_q > upper_q);
    pass1 = (state_q == ST_SETUP) && (below || above);
    diff  = above ? s_q - upper_q : s_q;
    // times ADC_HALF, which is all ones
    num1  = (NUM_W'(diff) << (ADC_BITS - 1)) - NUM_W'(diff);
    den1  = above ? ADC_MAX - upper_q : lower_q;

    if (state_q == ST_SETUP) begin
      v_sel = ADC_HALF;
    end else begin
      v_sel = ADC_BITS'(div_rsp.quo) + (above_q ? ADC_HALF : '0);
    end
    // times 255
    x = (X_W'(v_sel) << BYTE_W) - X_W'(v_sel);

    div_req.start = (state_q == ST_SETUP) ||
                    ((state_q == ST_PASS1) && div_rsp.done);
    if (pass1) begin
      div_req.ndig     = POS_DIGITS;
      div_req.rem_init = num1[NUM_W-1:Q_W];
      div_req.bits     = num1[Q_W-1:0];
      div_req.den      = den1;
    end else begin
      div_req.ndig     = BYTE_DIGITS;
      div_req.rem_init = x[X_W-1:BYTE_W];
      div_req.bits     = Q_W'(x[BYTE_W-1:0]) << (Q_W - BYTE_W);
      div_req.den      = ADC_MAX;
    end
  end

  jads_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (is_cal || !axis_ok) ? ST_DONE : ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_d = pass1 ? ST_PASS1 : ST_PASS2;
      end
      ST_PASS1: begin
        if (div_rsp.done) begin
          state_d = ST_PASS2;
        end
      end
      ST_PASS2: begin
        if (div_rsp.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= DEADZONE_RESET;
      stable_q <= STABLE_RESET;
      rev_x_q  <= 1'b0;
      rev_y_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEADZONE: radius_q <= cfg_data_i;
        CFG_STABLE:   stable_q <= cfg_data_i;
        CFG_REV_X:    rev_x_q  <= cfg_data_i[0];
        CFG_REV_Y:    rev_y_q  <= cfg_data_i[0];
      endcase
    end
  end

  // Calibration state: equal pairs count up, unequal pair clears, latch on need
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        centre_q[i] <= CENTRE_RESET;
        count_q[i]  <= '0;
      end
    end else if (accept && is_cal) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        if (int'(in_i.axis) == i) begin
          if (!pair_eq) begin
            count_q[i] <= '0;
          end else if (latch_now) begin
            centre_q[i] <= in_i.sample;
            cal_q[i]    <= 1'b1;
            count_q[i]  <= '0;
          end else begin
            count_q[i] <= cnt_inc;
          end
        end
      end
    end
  end

  // Item registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q       <= in_i.sample;
      axis_q    <= in_i.axis;
      rev_q     <= (in_i.axis == AXIS_W'(0)) ? rev_x_q : rev_y_q;
      lower_q   <= lower_d;
      upper_q   <= upper_d;
      res_pos_q <= '0;
      res_lat_q <= latch_now;
      res_cal_q <= axis_ok && (cal_sel || latch_now);
    end
    if (state_q == ST_SETUP) begin
      above_q <= above;
    end
    if ((state_q == ST_PASS2) && div_rsp.done) begin
      res_pos_q <= rev_q ? ~div_rsp.quo[BYTE_W-1:0] : div_rsp.quo[BYTE_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pos_q  <= res_pos_q;
      out_axis_q <= axis_q;
      out_cal_q  <= res_cal_q;
      out_lat_q  <= res_lat_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.position        = out_pos_q;
  assign out_o.axis_out        = out_axis_q;
  assign out_o.axis_calibrated = out_cal_q;
  assign out_o.centre_latched  = out_lat_q;

endmodule

/* rtl/core/jads_checker.sv */
module jads_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [jads_pkg::BYTE_W-1:0] position_i,
  input logic [jads_pkg::AXIS_W-1:0] axis_out_i,
  input logic                        axis_calibrated_i,
  input logic                        centre_latched_i
);

  // result waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped without a transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(position_i) && $stable(axis_out_i)
      && $stable(axis_calibrated_i) && $stable(centre_latched_i))
    else $error("stalled result changed");

  // one item in flight: input closes right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while one is in flight");

  // a latching calibration result reports a calibrated axis and a zero byte
  a_latch_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && centre_latched_i |-> axis_calibrated_i && (position_i == '0))
    else $error("latched centre with inconsistent result fields");

endmodule

bind joystick_axis_deadzone_scaler jads_checker u_jads_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .position_i        (out_o.position),
  .axis_out_i        (out_o.axis_out),
  .axis_calibrated_i (out_o.axis_calibrated),
  .centre_latched_i  (out_o.centre_latched)
);
